>>> hdl/lpd_pkg.sv
// Package for the length-prefixed deframer: request/result payload structs,
// result kind codes, config register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package lpd_pkg;

  localparam int HdrBytes   = 8;
  localparam int MaxLenBits = 21;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } lpd_kind_t;

  typedef enum logic [1:0] {
    CFG_TYPE_LOWER = 2'd0,
    CFG_TYPE_UPPER = 2'd1,
    CFG_MAX_LENGTH = 2'd2
  } lpd_cfg_idx_t;

  localparam logic signed [31:0]         TypeLowerReset = 32'sd0;
  localparam logic signed [31:0]         TypeUpperReset = 32'sd256;
  localparam logic [MaxLenBits-1:0]      MaxLengthReset = 21'd4096;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       new_connection;
  } lpd_in_t;

  typedef struct packed {
    lpd_kind_t          kind;
    logic signed [31:0] type_code;
    logic signed [31:0] msg_length;
    logic [7:0]         data_byte;
    logic               last;
  } lpd_out_t;

  typedef struct packed {
    logic signed [31:0]    type_lower_bound;
    logic signed [31:0]    type_upper_bound;
    logic [MaxLenBits-1:0] max_payload_length;
  } lpd_cfg_t;

endpackage

>>> hdl/lpd_parser.sv
// Header/payload parser state for the length-prefixed deframer; forms the
// result for the request being taken this cycle. Depends on lpd_pkg.
`timescale 1ns / 1ps

module lpd_parser (
  input  logic             clk,
  input  logic             rst,
  input  lpd_pkg::lpd_cfg_t cfg,
  input  logic             take,
  input  lpd_pkg::lpd_in_t rx,
  output logic             res_valid,
  output lpd_pkg::lpd_out_t res
);
  import lpd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } phase_t;

  phase_t                phase, phase_eff, phase_next;
  logic [2:0]            cnt, cnt_eff, cnt_next;
  logic [55:0]           sh, sh_eff, sh_next;
  logic [MaxLenBits-1:0] rem, rem_eff, rem_next;
  logic signed [31:0]    cur_type, cur_type_eff, cur_type_next;
  logic signed [31:0]    cur_len, cur_len_eff, cur_len_next;
  logic [63:0]           full;
  logic signed [31:0]    hdr_type, hdr_len;
  logic                  hdr_ok;

  always_comb begin
    // new_connection clears everything before the byte is used
    phase_eff    = rx.new_connection ? PH_HEADER : phase;
    cnt_eff      = rx.new_connection ? '0 : cnt;
    sh_eff       = rx.new_connection ? '0 : sh;
    rem_eff      = rx.new_connection ? '0 : rem;
    cur_type_eff = rx.new_connection ? '0 : cur_type;
    cur_len_eff  = rx.new_connection ? '0 : cur_len;

    full     = {rx.byte_in, sh_eff};
    hdr_type = $signed(full[31:0]);
    hdr_len  = $signed(full[63:32]);
    hdr_ok   = (hdr_type > cfg.type_lower_bound) && (hdr_type < cfg.type_upper_bound) &&
               !hdr_len[31] && (hdr_len[30:0] <= 31'(cfg.max_payload_length));

    phase_next    = phase_eff;
    cnt_next      = cnt_eff;
    sh_next       = sh_eff;
    rem_next      = rem_eff;
    cur_type_next = cur_type_eff;
    cur_len_next  = cur_len_eff;

    res_valid      = 1'b0;
    res.kind       = KIND_HEADER;
    res.type_code  = cur_type_eff;
    res.msg_length = cur_len_eff;
    res.data_byte  = '0;
    res.last       = 1'b0;

    unique case (phase_eff)
      PH_PAYLOAD: begin
        res_valid     = 1'b1;
        res.kind      = KIND_PAYLOAD;
        res.data_byte = rx.byte_in;
        res.last      = (rem_eff <= MaxLenBits'(1));
        if (rem_eff != '0) begin
          rem_next = rem_eff - MaxLenBits'(1);
        end
        if (rem_eff <= MaxLenBits'(1)) begin
          phase_next = PH_HEADER;
        end
      end
      PH_DROP: begin
        res_valid = 1'b0;
      end
      PH_HEADER: begin
        if (cnt_eff == 3'(HdrBytes - 1)) begin
          cnt_next       = '0;
          sh_next        = '0;
          cur_type_next  = hdr_type;
          cur_len_next   = hdr_len;
          res_valid      = 1'b1;
          res.type_code  = hdr_type;
          res.msg_length = hdr_len;
          if (!hdr_ok) begin
            phase_next = PH_DROP;
            res.kind   = KIND_ERROR;
          end else if (hdr_len == '0) begin
            phase_next = PH_HEADER;
            res.last   = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
            rem_next   = hdr_len[MaxLenBits-1:0];
          end
        end else begin
          sh_next  = full[63:8];
          cnt_next = cnt_eff + 3'd1;
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      cnt      <= '0;
      sh       <= '0;
      rem      <= '0;
      cur_type <= '0;
      cur_len  <= '0;
    end else if (take) begin
      phase    <= phase_next;
      cnt      <= cnt_next;
      sh       <= sh_next;
      rem      <= rem_next;
      cur_type <= cur_type_next;
      cur_len  <= cur_len_next;
    end
  end

`ifndef SYNTHESIS
  a_payload_has_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> rem != '0)
    else $error("payload phase with nothing remaining");

  a_empty_shift_at_start: assert property (@(posedge clk) disable iff (rst)
    cnt == '0 |-> sh == '0)
    else $error("stale header bytes at header start");

  a_error_drops: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.kind == KIND_ERROR |=> phase == PH_DROP)
    else $error("bad header did not enter drop phase");

  a_last_ends_payload: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.kind == KIND_PAYLOAD && res.last |=> phase == PH_HEADER)
    else $error("last payload byte did not return to header phase");
`endif

endmodule

>>> hdl/length_prefixed_deframer.sv
// Top level of the length-prefixed deframer: config registers, parser and
// result register. Depends on lpd_pkg and lpd_parser.
`timescale 1ns / 1ps

// Usage:
//   rx_*  : one stream byte per request, with new_connection to restart the
//           parser at a header before that byte is used.
//   evt_* : results - header (kind 0), payload byte (kind 1) or bad header
//           error (kind 2). Header bytes 1..7 and bytes after an error
//           produce no result.
//   cfg_* : register writes (index 0 type lower bound, 1 type upper bound,
//           2 max payload length); always ready, write only while idle.
// Result: a result is registered and appears on evt_* in the cycle after its request is taken.
// Throughput: one request per cycle while rx_ready is high; the parser step is
//   combinational logic in front of one result register.
// Stall: rx_ready drops only while a result sits in the result register and
//   evt_ready is low; a request that yields no result still needs that slot.
// Reset: rst (synchronous) empties the result register, returns the parser to
//   header start and loads the register reset values (0, 256, 4096).
module length_prefixed_deframer (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_ready,
  input  lpd_pkg::lpd_in_t  rx_data,
  output logic              evt_valid,
  input  logic              evt_ready,
  output lpd_pkg::lpd_out_t evt_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import lpd_pkg::*;

  lpd_cfg_t cfg;
  logic     take;
  logic     res_valid;
  lpd_out_t res;

  assign cfg_ready = 1'b1;
  assign rx_ready  = !evt_valid || evt_ready;
  assign take      = rx_valid && rx_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.type_lower_bound   <= TypeLowerReset;
      cfg.type_upper_bound   <= TypeUpperReset;
      cfg.max_payload_length <= MaxLengthReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TYPE_LOWER: cfg.type_lower_bound   <= $signed(cfg_data);
        CFG_TYPE_UPPER: cfg.type_upper_bound   <= $signed(cfg_data);
        CFG_MAX_LENGTH: cfg.max_payload_length <= cfg_data[MaxLenBits-1:0];
        default: begin
        end
      endcase
    end
  end

  lpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .rx        (rx_data),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (take) begin
      evt_valid <= res_valid;
    end else if (evt_ready) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      evt_data <= res;
    end
  end

endmodule
